[hw/rtl/sdah_pkg.sv]
// Shared widths, register codes, types and helpers for the stick direction averager.
package sdah_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WLEN_W     = 7;
  localparam int THR_W      = 16;
  localparam int SMP_W      = 16;
  localparam int SUM_W      = SMP_W + IDX_W;
  localparam int DIV_W      = IDX_W + 1;
  localparam int SQ_W       = 2 * SMP_W;
  localparam int STEP_W     = $clog2(SMP_W);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_THR    = CFG_IDX_W'(1);

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(8);

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam smp_t HOLD_Z_RESET = 16'sh7FFF;

  // zero is taken as one, anything above the ring depth saturates
  function automatic logic [WLEN_W-1:0] clamp_len(input logic [WLEN_W-1:0] v);
    logic [WLEN_W-1:0] r;
    r = v;
    if (v == '0) r = WLEN_W'(1);
    else if (int'(v) > MAX_WINDOW) r = WLEN_W'(MAX_WINDOW);
    return r;
  endfunction

endpackage

[hw/rtl/sdah_if.sv]
// Request channel interfaces: stick samples in, held direction out.
interface sdah_in_if import sdah_pkg::*; ();
  logic valid;
  logic ready;
  smp_t stick_x;
  smp_t stick_y;
  modport source (output valid, output stick_x, output stick_y, input ready);
  modport sink   (input valid, input stick_x, input stick_y, output ready);
endinterface

interface sdah_out_if import sdah_pkg::*; ();
  logic valid;
  logic ready;
  smp_t held_x;
  smp_t held_z;
  logic updated;
  modport source (output valid, output held_x, output held_z, output updated, input ready);
  modport sink   (input valid, input held_x, input held_z, input updated, output ready);
endinterface

[hw/rtl/sdah_div.sv]
// Bit-serial restoring divider: signed window sum by window length, truncating toward zero.
module sdah_div import sdah_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  sum_t             dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output smp_t             quotient
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [IDX_W-1:0]  rem_r;
  logic [SMP_W-1:0]  q_r;
  logic              neg_r;
  logic [SUM_W-1:0]  mag;
  logic [DIV_W-1:0]  trial;
  logic              fits;
  logic [DIV_W-1:0]  diff;

  assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
  assign trial = {rem_r, q_r[SMP_W-1]};
  assign fits  = trial >= divisor;
  assign diff  = trial - divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(SMP_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) busy_r <= 1'b0;
        else cnt_r <= cnt_r - STEP_W'(1);
      end
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= mag[SUM_W-1:SMP_W];
      q_r   <= mag[SMP_W-1:0];
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      rem_r <= fits ? diff[IDX_W-1:0] : trial[IDX_W-1:0];
      q_r   <= {q_r[SMP_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? smp_t'(-q_r) : smp_t'(q_r);

endmodule

[hw/rtl/sdah_sq.sv]
// Bit-serial shift-add squarer for a 16-bit magnitude.
module sdah_sq import sdah_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SMP_W-1:0] a,
  output logic             done,
  output logic [SQ_W-1:0]  sq
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [SMP_W-1:0]  mcand_r;
  logic [SQ_W-1:0]   prod_r;
  logic [SMP_W:0]    part;

  assign part = {1'b0, prod_r[SQ_W-1:SMP_W]} + (prod_r[0] ? {1'b0, mcand_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(SMP_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) busy_r <= 1'b0;
        else cnt_r <= cnt_r - STEP_W'(1);
      end
    end
  end

  // multiplier sits in the low half and is consumed one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= a;
      prod_r  <= {{SMP_W{1'b0}}, a};
    end else if (busy_r) begin
      prod_r <= {part, prod_r[SMP_W-1:1]};
    end
  end

  assign done = done_r;
  assign sq   = prod_r;

endmodule

[hw/rtl/stick_direction_average_hold.sv]
// Top level: sample ring, running sums, serial divide and square, held direction.
//
//   channel  | dir | payload                         | accepted when
//   in_chan  | in  | stick_x, stick_y                | valid && ready
//   out_chan | out | held_x, held_z, updated         | valid && ready
//   cfg_*    | in  | cfg_index, cfg_wdata            | cfg_we high
//
// A request passes through ring read and sum update, divider load and 16 steps, squarer load
// and 16 steps and the hand-off, which waits until the output register is free; the next
// request is taken once the block is back in idle.
// in_chan.ready is high only while idle; a finished result waits in the output register.
// Reset clears the ring through per-slot valid bits.
// A window_len write runs a pass over every ring slot that rebuilds the sums; no request is taken then.
module stick_direction_average_hold import sdah_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  sdah_in_if.sink               in_chan,
  sdah_out_if.source            out_chan
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_DIVW  = 3'd2;
  localparam logic [2:0] ST_SQW   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_SWEEP = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [WLEN_W-1:0]     wlen_r;
  logic [THR_W-1:0]      thr_r;
  logic [IDX_W-1:0]      slot_pos_r;
  logic [MAX_WINDOW-1:0] valid_r;
  sum_t                  sum_x_r, sum_y_r;
  sum_t                  sum_x_nxt, sum_y_nxt;
  smp_t                  x_r, y_r;
  smp_t                  hold_x_r, hold_z_r;
  logic                  upd_r;
  logic [IDX_W:0]        sweep_cnt_r;
  logic [2*SMP_W-1:0]    ring_mem [MAX_WINDOW];
  logic [2*SMP_W-1:0]    rd_data_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  out_valid_r;
  smp_t                  out_x_r, out_z_r;
  logic                  out_upd_r;

  logic                  in_take;
  logic                  cfg_wlen_wr;
  logic [WLEN_W-1:0]     wlen_new;
  smp_t                  old_x, old_y, rd_x, rd_y;
  logic [IDX_W:0]        slot_inc;
  logic                  div_done_x, div_done_y;
  smp_t                  qx, qy;
  logic                  sq_start;
  logic                  sq_done_x, sq_done_y, sq_done_t;
  logic [SQ_W-1:0]       sqx, sqy, sqt;
  logic                  above;
  logic                  out_free;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_take       = in_chan.valid && in_chan.ready;
  assign cfg_wlen_wr   = cfg_we && (cfg_index == CFG_WINDOW_LEN);
  assign wlen_new      = clamp_len(cfg_wdata[WLEN_W-1:0]);

  assign rd_addr = (state_r == ST_SWEEP) ? sweep_cnt_r[IDX_W-1:0] : slot_pos_r;
  assign rd_x    = smp_t'(rd_data_r[2*SMP_W-1:SMP_W]);
  assign rd_y    = smp_t'(rd_data_r[SMP_W-1:0]);
  assign old_x   = valid_r[slot_pos_r] ? rd_x : '0;
  assign old_y   = valid_r[slot_pos_r] ? rd_y : '0;
  assign slot_inc = {1'b0, slot_pos_r} + (IDX_W+1)'(1);

  assign sum_x_nxt = sum_x_r + SUM_W'(x_r) - SUM_W'(old_x);
  assign sum_y_nxt = sum_y_r + SUM_W'(y_r) - SUM_W'(old_y);

  assign sq_start = (state_r == ST_DIVW) && div_done_x;
  assign above    = ({1'b0, sqx} + {1'b0, sqy}) > {1'b0, sqt};
  assign out_free = !out_valid_r || out_chan.ready;

  sdah_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_RD),
    .dividend (sum_x_nxt),
    .divisor  (DIV_W'(wlen_r)),
    .done     (div_done_x),
    .quotient (qx)
  );

  sdah_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_RD),
    .dividend (sum_y_nxt),
    .divisor  (DIV_W'(wlen_r)),
    .done     (div_done_y),
    .quotient (qy)
  );

  sdah_sq u_sq_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .a     (qx[SMP_W-1] ? SMP_W'(-qx) : SMP_W'(qx)),
    .done  (sq_done_x),
    .sq    (sqx)
  );

  sdah_sq u_sq_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .a     (qy[SMP_W-1] ? SMP_W'(-qy) : SMP_W'(qy)),
    .done  (sq_done_y),
    .sq    (sqy)
  );

  sdah_sq u_sq_t (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .a     (thr_r),
    .done  (sq_done_t),
    .sq    (sqt)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_take) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_DIVW;
      ST_DIVW:  if (div_done_x) state_nxt = ST_SQW;
      ST_SQW:   if (sq_done_x) state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      ST_SWEEP: if (sweep_cnt_r == (IDX_W+1)'(MAX_WINDOW)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (cfg_wlen_wr) state_nxt = ST_SWEEP;
  end

  always_ff @(posedge clk) begin
    if (ST_RD == state_r) ring_mem[slot_pos_r] <= {x_r, y_r};
    rd_data_r <= ring_mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r <= in_chan.stick_x;
      y_r <= in_chan.stick_y;
    end
    if (state_r == ST_FIN && out_free) begin
      out_x_r   <= hold_x_r;
      out_z_r   <= hold_z_r;
      out_upd_r <= upd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wlen_r      <= WLEN_RESET;
      thr_r       <= '0;
      slot_pos_r  <= '0;
      valid_r     <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      hold_x_r    <= '0;
      hold_z_r    <= HOLD_Z_RESET;
      upd_r       <= 1'b0;
      sweep_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_RD) begin
        sum_x_r             <= sum_x_nxt;
        sum_y_r             <= sum_y_nxt;
        valid_r[slot_pos_r] <= 1'b1;
        slot_pos_r <= (slot_inc >= (IDX_W+1)'(wlen_r)) ? '0 : slot_inc[IDX_W-1:0];
      end

      if (state_r == ST_SWEEP) begin
        if (sweep_cnt_r != '0 && valid_r[rd_idx_r]) begin
          sum_x_r <= sum_x_r + SUM_W'(rd_x);
          sum_y_r <= sum_y_r + SUM_W'(rd_y);
        end
        if (sweep_cnt_r != (IDX_W+1)'(MAX_WINDOW)) sweep_cnt_r <= sweep_cnt_r + (IDX_W+1)'(1);
      end

      if (state_r == ST_SQW && sq_done_x) begin
        upd_r <= above;
        if (above) begin
          hold_x_r <= qx;
          hold_z_r <= qy;
        end
      end

      if (state_r == ST_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;

      if (cfg_we && cfg_index == CFG_CUT_THR) thr_r <= cfg_wdata[THR_W-1:0];

      // resize: drop slots beyond the new window, then rebuild the sums
      if (cfg_wlen_wr) begin
        wlen_r      <= wlen_new;
        sweep_cnt_r <= '0;
        sum_x_r     <= '0;
        sum_y_r     <= '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
          if ((IDX_W+1)'(i) >= (IDX_W+1)'(wlen_new)) valid_r[i] <= 1'b0;
        end
        if ((IDX_W+1)'(slot_pos_r) >= (IDX_W+1)'(wlen_new)) slot_pos_r <= '0;
      end
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.held_x  = out_x_r;
  assign out_chan.held_z  = out_z_r;
  assign out_chan.updated = out_upd_r;

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (IDX_W+1)'(slot_pos_r) < (IDX_W+1)'(wlen_r))
    else $error("ring slot outside window");

  a_wlen_range: assert property (@(posedge clk) disable iff (!rst_n)
    wlen_r != '0 && int'(wlen_r) <= MAX_WINDOW)
    else $error("window length out of range");

  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    div_done_x == div_done_y && sq_done_x == sq_done_y && sq_done_x == sq_done_t &&
    (!div_done_x || state_r == ST_DIVW))
    else $error("divider completion out of step");

  a_sq_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQW && sq_done_x && !cfg_wlen_wr) |=> state_r == ST_FIN)
    else $error("squarer completion did not reach hand-off");

  a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !in_chan.ready)
    else $error("request taken during sum rebuild");

endmodule
